/* rtl/eth_frame_builder_crc32_assert.svh */
// assertion macros shared by the checker
`ifndef ETH_FRAME_BUILDER_CRC32_ASSERT_SVH
`define ETH_FRAME_BUILDER_CRC32_ASSERT_SVH

// same-cycle implication
`define EFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("efb assertion failed");

// next-cycle implication
`define EFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("efb assertion failed");

`endif

/* rtl/efb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package efb_pkg;

	localparam int BYTE_W     = 8;
	localparam int MAC_W      = 48;
	localparam int ETYPE_W    = 16;
	localparam int CRC_W      = 32;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = MAC_W;

	// header: 6 destination, 6 source, 2 type bytes
	localparam int HDR_LEN   = 14;
	localparam int HDR_IDX_W = 4;
	localparam int FCS_LEN   = 4;
	localparam int FCS_IDX_W = 2;

	localparam logic [CRC_W-1:0]   CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0]   CRC_POLY = 32'hEDB8_8320;
	localparam logic [MAC_W-1:0]   DEST_MAC_RST   = 48'd67969075013940;
	localparam logic [MAC_W-1:0]   SOURCE_MAC_RST = 48'd57313195796797;
	localparam logic [ETYPE_W-1:0] ETHER_TYPE_RST = 16'h0800;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DEST_MAC   = 2'd0,
		REG_SOURCE_MAC = 2'd1,
		REG_ETHER_TYPE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              update;
		logic              clear;
		logic [BYTE_W-1:0] data;
	} crc_ctl_t;

	// reflected crc-32, one byte folded in
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/efb_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// payload byte channel
interface efb_in_if import efb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic              last_byte;

	modport source(output valid, output payload_byte, output last_byte, input ready);
	modport sink(input valid, input payload_byte, input last_byte, output ready);
endinterface

// frame byte channel
interface efb_out_if import efb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_end;

	modport source(output valid, output frame_byte, output frame_end, input ready);
	modport sink(input valid, input frame_byte, input frame_end, output ready);
endinterface

// register write channel
interface efb_cfg_if import efb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output addr, output data, input ready);
	modport sink(input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* rtl/eth_frame_builder_crc32.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel     dir   payload                      notes
// payload_ch  in    payload_byte[7:0], last_byte  one request per payload byte
// frame_ch    out   frame_byte[7:0], frame_end    header, payload, fcs bytes
// cfg         in    addr[1:0], data[47:0]         register writes, always ready
//
// one frame byte leaves per cycle while frame_ch is ready, from a registered output stage.
// the first payload byte of a frame goes out behind the 14 header bytes, and the
// last payload byte is followed by the 4 fcs bytes.
// the one-byte crc update between the byte mux and the crc register sets the path.
// reset clears the input and output stages, the frame state and loads crc all ones.
// a stall on frame_ch holds the output byte and backs up into payload_ch.ready.

module eth_frame_builder_crc32 import efb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	efb_in_if.sink    payload_ch,
	efb_out_if.source frame_ch,
	efb_cfg_if.sink   cfg
);

	localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_LEN - 1);
	localparam logic [FCS_IDX_W-1:0] FCS_LAST = FCS_IDX_W'(FCS_LEN - 1);

	// configuration registers
	logic [MAC_W-1:0]   dest_mac_q;
	logic [MAC_W-1:0]   source_mac_q;
	logic [ETYPE_W-1:0] ether_type_q;

	// input stage
	logic              item_v_s1;
	logic [BYTE_W-1:0] item_byte_s1;
	logic              item_last_s1;

	// frame sequencing
	logic                 in_frame_q;
	logic [HDR_IDX_W-1:0] hdr_idx_q;
	logic                 fcs_act_q;
	logic [FCS_IDX_W-1:0] fcs_idx_q;

	// output stage
	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_end_q;

	logic              can_emit;
	logic              emit_fcs;
	logic              emit_hdr;
	logic              emit_pay;
	logic [BYTE_W-1:0] hdr_byte;
	logic [BYTE_W-1:0] fcs_byte;
	logic [CRC_W-1:0]  crc;
	logic [CRC_W-1:0]  fcs_word;
	crc_ctl_t          crc_ctl;

	// register writes, unknown index ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_mac_q   <= DEST_MAC_RST;
			source_mac_q <= SOURCE_MAC_RST;
			ether_type_q <= ETHER_TYPE_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_DEST_MAC:   dest_mac_q   <= cfg.data;
				REG_SOURCE_MAC: source_mac_q <= cfg.data;
				REG_ETHER_TYPE: ether_type_q <= cfg.data[ETYPE_W-1:0];
				default: ;
			endcase
		end
	end

	// output slot is free or being drained this cycle
	assign can_emit = !out_v_q || frame_ch.ready;

	// fcs first, then header ahead of the first payload byte, then payload
	assign emit_fcs = can_emit && fcs_act_q;
	assign emit_hdr = can_emit && !fcs_act_q && item_v_s1 && !in_frame_q;
	assign emit_pay = can_emit && !fcs_act_q && item_v_s1 && in_frame_q;

	// input slot refills in the cycle its byte goes out
	assign payload_ch.ready = !item_v_s1 || emit_pay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (payload_ch.ready) begin
			item_v_s1 <= payload_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload_ch.ready && payload_ch.valid) begin
			item_byte_s1 <= payload_ch.payload_byte;
			item_last_s1 <= payload_ch.last_byte;
		end
	end

	// header byte by position: dest msb first, source msb first, type low first
	always_comb begin
		case (hdr_idx_q)
			4'd0:    hdr_byte = dest_mac_q[47:40];
			4'd1:    hdr_byte = dest_mac_q[39:32];
			4'd2:    hdr_byte = dest_mac_q[31:24];
			4'd3:    hdr_byte = dest_mac_q[23:16];
			4'd4:    hdr_byte = dest_mac_q[15:8];
			4'd5:    hdr_byte = dest_mac_q[7:0];
			4'd6:    hdr_byte = source_mac_q[47:40];
			4'd7:    hdr_byte = source_mac_q[39:32];
			4'd8:    hdr_byte = source_mac_q[31:24];
			4'd9:    hdr_byte = source_mac_q[23:16];
			4'd10:   hdr_byte = source_mac_q[15:8];
			4'd11:   hdr_byte = source_mac_q[7:0];
			4'd12:   hdr_byte = ether_type_q[7:0];
			4'd13:   hdr_byte = ether_type_q[15:8];
			default: hdr_byte = '0;
		endcase
	end

	// fcs is the inverted crc, low byte first
	assign fcs_word = ~crc;
	assign fcs_byte = fcs_word[BYTE_W*fcs_idx_q +: BYTE_W];

	// crc folds every header and payload byte, restarts after the last fcs byte
	always_comb begin
		crc_ctl.update = emit_hdr || emit_pay;
		crc_ctl.clear  = emit_fcs && (fcs_idx_q == FCS_LAST);
		crc_ctl.data   = emit_hdr ? hdr_byte : item_byte_s1;
	end

	efb_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	// frame sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			hdr_idx_q  <= '0;
			fcs_act_q  <= 1'b0;
			fcs_idx_q  <= '0;
		end else begin
			if (emit_hdr) begin
				if (hdr_idx_q == HDR_LAST) begin
					hdr_idx_q  <= '0;
					in_frame_q <= 1'b1;
				end else begin
					hdr_idx_q <= hdr_idx_q + 1'b1;
				end
			end
			if (emit_pay && item_last_s1) begin
				fcs_act_q <= 1'b1;
				fcs_idx_q <= '0;
			end
			if (emit_fcs) begin
				fcs_idx_q <= fcs_idx_q + 1'b1;
				if (fcs_idx_q == FCS_LAST) begin
					fcs_act_q  <= 1'b0;
					in_frame_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (can_emit) begin
			out_v_q <= emit_fcs || emit_hdr || emit_pay;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fcs) begin
			out_byte_q <= fcs_byte;
			out_end_q  <= (fcs_idx_q == FCS_LAST);
		end else if (emit_hdr) begin
			out_byte_q <= hdr_byte;
			out_end_q  <= 1'b0;
		end else if (emit_pay) begin
			out_byte_q <= item_byte_s1;
			out_end_q  <= 1'b0;
		end
	end

	assign frame_ch.valid      = out_v_q;
	assign frame_ch.frame_byte = out_byte_q;
	assign frame_ch.frame_end  = out_end_q;

endmodule

`default_nettype wire

/* rtl/efb_crc.sv */
`timescale 1ns / 1ps
`default_nettype none

module efb_crc import efb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire crc_ctl_t         ctl,
	output logic      [CRC_W-1:0] crc
);

	logic [CRC_W-1:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.clear) begin
			crc_q <= CRC_INIT;
		end else if (ctl.update) begin
			crc_q <= crc_byte(crc_q, ctl.data);
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

/* rtl/efb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "eth_frame_builder_crc32_assert.svh"

module efb_assert_checker import efb_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [BYTE_W-1:0] out_byte,
	input wire logic              out_end
);

	// smallest frame: header, one payload byte, fcs
	localparam int MIN_FRAME = HDR_LEN + 1 + FCS_LEN;
	localparam int CNT_W     = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic             out_acc;
	logic [CNT_W-1:0] frame_cnt_q;

	assign out_acc = out_valid && out_ready;

	// bytes delivered since the last frame end, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
		end else if (out_acc) begin
			if (out_end) begin
				frame_cnt_q <= '0;
			end else if (frame_cnt_q != CNT_MAX) begin
				frame_cnt_q <= frame_cnt_q + 1'b1;
			end
		end
	end

	`EFB_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`EFB_ASSERT_NEXT(a_byte_hold, clk, arst_n, out_valid && !out_ready, $stable(out_byte) && $stable(out_end))
	`EFB_ASSERT_NOW(a_end_min_len, clk, arst_n, out_acc && out_end, frame_cnt_q >= CNT_W'(MIN_FRAME - 1))

endmodule

bind eth_frame_builder_crc32 efb_assert_checker u_efb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (frame_ch.valid),
	.out_ready (frame_ch.ready),
	.out_byte  (frame_ch.frame_byte),
	.out_end   (frame_ch.frame_end)
);

`default_nettype wire
